>>> rtl/fastr_pkg.sv
// Shared types and codes for the four-axis step, teach and replay sequencer.
package fastr_pkg;

  // Operator command codes carried in tuser
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_SELECT  = 3'd1;
  localparam logic [2:0] CMD_LEFT    = 3'd2;
  localparam logic [2:0] CMD_RIGHT   = 3'd3;
  localparam logic [2:0] CMD_SAVE    = 3'd4;
  localparam logic [2:0] CMD_REPLAY  = 3'd5;
  localparam logic [2:0] CMD_RECAL   = 3'd6;

  // Sequencer modes
  localparam logic [2:0] M_IDLE        = 3'd0;
  localparam logic [2:0] M_HOME_END    = 3'd1;
  localparam logic [2:0] M_HOME_STEP   = 3'd2;
  localparam logic [2:0] M_STEPPING    = 3'd3;
  localparam logic [2:0] M_REPLAY_LOAD = 3'd4;
  localparam logic [2:0] M_REPLAY_MOVE = 3'd5;

  // Drive directions
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_ONE   = 2'd0;
  localparam logic [1:0] REG_MAX_TWO   = 2'd1;
  localparam logic [1:0] REG_MAX_THREE = 2'd2;
  localparam logic [1:0] REG_MAX_FOUR  = 2'd3;

  localparam logic [7:0] MAX_ONE_RST   = 8'h4E;
  localparam logic [7:0] MAX_TWO_RST   = 8'h4E;
  localparam logic [7:0] MAX_THREE_RST = 8'h36;
  localparam logic [7:0] MAX_FOUR_RST  = 8'h11;

  // Classified item handed from front to back
  typedef struct packed {
    logic       is_cmd;      // command 1..6, subject to busy refusal
    logic [2:0] cmd;
    logic [1:0] choice;
    logic [3:0] ends;
    logic [3:0] pulses;
  } item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] taught_count;
    logic [1:0] selected_now;
    logic [7:0] selected_position;
    logic       refused;
    logic       at_limit;
    logic       busy_res;
    logic [1:0] drive_dir;
    logic [1:0] drive_axis;
  } res_t;

endpackage

>>> rtl/fastr_front.sv
// Front stage: accept stream items and classify the command.
module fastr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_cmd,
  input  logic [15:0]          in_data,
  output logic                 f_valid,
  input  logic                 f_ready,
  output fastr_pkg::item_t     f_item
);
  import fastr_pkg::*;

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_item.is_cmd <= (in_cmd != CMD_TICK) && (in_cmd <= CMD_RECAL);
      f_item.cmd    <= in_cmd;
      f_item.choice <= in_data[1:0];
      f_item.ends   <= in_data[5:2];
      f_item.pulses <= in_data[9:6];
    end
  end

endmodule

>>> rtl/fastr_queue.sv
// Two-entry queue between front and back.
module fastr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             w_valid,
  output logic             w_ready,
  input  fastr_pkg::item_t w_item,
  output logic             r_valid,
  input  logic             r_ready,
  output fastr_pkg::item_t r_item
);
  import fastr_pkg::*;

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign w_ready = (cnt != 2'd2);
  assign r_valid = (cnt != 2'd0);
  assign r_item  = slots[rp];
  assign push    = w_valid && w_ready;
  assign pop     = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= w_item;
  end

endmodule

>>> rtl/fastr_back.sv
// Back end: homing, stepping and replay sequencer with teach memory and result register.
module fastr_back #(
  parameter int TEACH_DEPTH   = 128,
  parameter int AXIS_COUNT    = 4,
  parameter int POSITION_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  fastr_pkg::item_t q_item,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [7:0]       cfg_val,
  output logic             o_valid,
  input  logic             o_ready,
  output fastr_pkg::res_t  o_res
);
  import fastr_pkg::*;

  localparam int PB     = POSITION_BITS;
  localparam int ADDR_W = (TEACH_DEPTH > 1) ? $clog2(TEACH_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TEACH_DEPTH + 1);
  localparam int PMASK  = (1 << POSITION_BITS) - 1;

  typedef struct packed {
    logic          ok;
    logic          lim;
    logic          outward;
    logic [PB-1:0] tgt;
  } mv_t;

  typedef struct packed {
    logic          done;
    logic          seen;
    logic          stepped;
    logic [PB-1:0] pos;
  } adv_t;

  logic [7:0]        maxr [4];
  logic [2:0]        mode, mode_next;
  logic [2:0]        act, act_next;
  logic [PB-1:0]     pos [AXIS_COUNT];
  logic [PB-1:0]     pos_next [AXIS_COUNT];
  logic [1:0]        chosen, chosen_next;
  logic [PB-1:0]     tgt, tgt_next;
  logic              outw, outw_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic              lim, lim_next;
  logic              seen, seen_next;
  logic [PB+1:0]     mem [TEACH_DEPTH];
  logic [PB+1:0]     rd;
  logic              we;
  logic [PB+1:0]     wdata;
  logic [CNT_W-1:0]  raddr;
  logic              fire;
  res_t              res;

  function automatic logic [PB-1:0] pos_of(input logic [2:0] a,
                                            input logic [PB-1:0] p [AXIS_COUNT]);
    logic [PB-1:0] v;
    v = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      if (a == 3'(i)) v = p[i];
    end
    return v;
  endfunction

  function automatic logic [7:0] max_of(input logic [2:0] a, input logic [7:0] m [4]);
    return a[2] ? 8'd0 : m[a[1:0]];
  endfunction

  // Check the first step toward a target and set up the move.
  function automatic mv_t start_move(input logic [2:0] a, input int target,
                                     input logic [PB-1:0] posv, input logic [7:0] mx);
    mv_t r;
    int p;
    int n;
    logic [31:0] t;
    p = int'(posv);
    t = 32'(target);
    r.ok = 1'b0;
    r.lim = 1'b0;
    r.outward = target > p;
    r.tgt = t[PB-1:0];
    if (int'(a) >= AXIS_COUNT) begin
      r.lim = 1'b1;
    end else if (target != p) begin
      n = (target > p) ? p + 1 : p - 1;
      if (n < 1 || n > int'(mx) || n > PMASK) r.lim = 1'b1;
      else r.ok = 1'b1;
    end
    return r;
  endfunction

  // One pulse-counted step: count on a high level after a low was seen.
  function automatic adv_t advance(input logic a_ok, input logic pbit, input logic sl,
                                   input logic ow, input logic [PB-1:0] posv,
                                   input logic [PB-1:0] tg);
    adv_t r;
    r.done = 1'b0;
    r.seen = sl;
    r.stepped = 1'b0;
    r.pos = posv;
    if (!a_ok) begin
      r.done = 1'b1;
    end else if (!pbit) begin
      r.seen = 1'b1;
    end else if (sl) begin
      r.seen = 1'b0;
      r.stepped = 1'b1;
      r.pos = ow ? posv + 1'b1 : posv - 1'b1;
      r.done = (r.pos == tg);
    end
    return r;
  endfunction

  assign fire    = q_valid && (!o_valid || o_ready);
  assign q_ready = !o_valid || o_ready;
  assign raddr   = fire ? ptr_next : ptr;

  always_comb begin
    mv_t           mv;
    adv_t          ad;
    logic          a_ok;
    logic          pbit;
    logic          ebit;
    logic [PB-1:0] pv;
    logic [PB-1:0] cp;
    logic [1:0]    dir;
    logic          refused;

    mode_next   = mode;
    act_next    = act;
    chosen_next = chosen;
    tgt_next    = tgt;
    outw_next   = outw;
    cnt_next    = cnt;
    ptr_next    = ptr;
    lim_next    = lim;
    seen_next   = seen;
    for (int i = 0; i < AXIS_COUNT; i++) pos_next[i] = pos[i];
    we      = 1'b0;
    wdata   = '0;
    refused = 1'b0;
    mv      = '0;
    ad      = '0;

    a_ok = int'(act) < AXIS_COUNT;
    pbit = act[2] ? 1'b0 : q_item.pulses[act[1:0]];
    ebit = act[2] ? 1'b0 : q_item.ends[act[1:0]];

    unique case (mode)
      M_HOME_END: begin
        if (ebit) begin
          for (int i = 0; i < AXIS_COUNT; i++) begin
            if (act == 3'(i)) pos_next[i] = '0;
          end
          mv = start_move(act, 1, '0, max_of(act, maxr));
          lim_next = mv.lim;
          if (mv.ok) begin
            outw_next = mv.outward;
            tgt_next  = mv.tgt;
            seen_next = 1'b0;
            mode_next = M_HOME_STEP;
          end else if (int'(act) + 1 < AXIS_COUNT) begin
            act_next = act + 3'd1;
          end else begin
            mode_next = M_IDLE;
          end
        end
      end
      M_HOME_STEP, M_STEPPING, M_REPLAY_MOVE: begin
        ad = advance(a_ok, pbit, seen, outw, pos_of(act, pos), tgt);
        seen_next = ad.seen;
        for (int i = 0; i < AXIS_COUNT; i++) begin
          if (ad.stepped && act == 3'(i)) pos_next[i] = ad.pos;
        end
        if (ad.done) begin
          if (mode == M_HOME_STEP) begin
            if (int'(act) + 1 < AXIS_COUNT) begin
              act_next  = act + 3'd1;
              mode_next = M_HOME_END;
            end else begin
              mode_next = M_IDLE;
            end
          end else if (mode == M_STEPPING) begin
            mode_next = M_IDLE;
          end else begin
            ptr_next  = ptr + 1'b1;
            mode_next = M_REPLAY_LOAD;
          end
        end
      end
      M_REPLAY_LOAD: begin
        if (ptr >= cnt || int'(ptr) >= TEACH_DEPTH) begin
          mode_next = M_IDLE;
        end else begin
          act_next = {1'b0, rd[PB+1:PB]};
          mv = start_move(act_next, int'(rd[PB-1:0]), pos_of(act_next, pos),
                          max_of(act_next, maxr));
          lim_next = mv.lim;
          if (mv.ok) begin
            outw_next = mv.outward;
            tgt_next  = mv.tgt;
            seen_next = 1'b0;
            mode_next = M_REPLAY_MOVE;
          end else begin
            ptr_next = ptr + 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Commands see the mode left by this tick's motion update
    cp = pos_of({1'b0, chosen_next}, pos_next);
    if (q_item.is_cmd) begin
      if (mode_next != M_IDLE) begin
        refused = 1'b1;
      end else begin
        unique case (q_item.cmd)
          CMD_SELECT: begin
            if (int'(q_item.choice) < AXIS_COUNT) chosen_next = q_item.choice;
          end
          CMD_LEFT, CMD_RIGHT: begin
            act_next = {1'b0, chosen_next};
            mv = start_move(act_next,
                            (q_item.cmd == CMD_LEFT) ? int'(cp) - 1 : int'(cp) + 1,
                            cp, max_of(act_next, maxr));
            lim_next = mv.lim;
            if (mv.ok) begin
              outw_next = mv.outward;
              tgt_next  = mv.tgt;
              seen_next = 1'b0;
              mode_next = M_STEPPING;
            end
          end
          CMD_SAVE: begin
            if (int'(cnt_next) >= TEACH_DEPTH || int'(chosen_next) >= AXIS_COUNT) begin
              refused = 1'b1;
            end else begin
              we       = 1'b1;
              wdata    = {chosen_next, cp};
              cnt_next = cnt_next + 1'b1;
            end
          end
          CMD_REPLAY: begin
            if (cnt_next != '0) begin
              ptr_next  = '0;
              mode_next = M_REPLAY_LOAD;
            end
          end
          default: begin
            chosen_next = '0;
            cnt_next    = '0;
            ptr_next    = '0;
            act_next    = '0;
            mode_next   = M_HOME_END;
          end
        endcase
      end
    end

    if (mode_next == M_HOME_END) dir = DIR_CCW;
    else if (mode_next == M_HOME_STEP || mode_next == M_STEPPING ||
             mode_next == M_REPLAY_MOVE) dir = outw_next ? DIR_CW : DIR_CCW;
    else dir = DIR_STOP;

    pv = pos_of({1'b0, chosen_next}, pos_next);
    res.pad               = '0;
    res.drive_axis        = act_next[1:0];
    res.drive_dir         = dir;
    res.busy_res          = (mode_next != M_IDLE);
    res.at_limit          = lim_next;
    res.refused           = refused;
    res.selected_position = 8'(32'(pv));
    res.selected_now      = chosen_next;
    res.taught_count      = 8'(32'(cnt_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_HOME_END;
      act     <= '0;
      chosen  <= '0;
      tgt     <= '0;
      outw    <= 1'b0;
      cnt     <= '0;
      ptr     <= '0;
      lim     <= 1'b0;
      seen    <= 1'b0;
      o_valid <= 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) pos[i] <= '0;
      maxr[0] <= MAX_ONE_RST;
      maxr[1] <= MAX_TWO_RST;
      maxr[2] <= MAX_THREE_RST;
      maxr[3] <= MAX_FOUR_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_MAX_ONE:   maxr[0] <= cfg_val;
          REG_MAX_TWO:   maxr[1] <= cfg_val;
          REG_MAX_THREE: maxr[2] <= cfg_val;
          REG_MAX_FOUR:  maxr[3] <= cfg_val;
          default: ;
        endcase
      end
      if (fire) begin
        mode   <= mode_next;
        act    <= act_next;
        chosen <= chosen_next;
        tgt    <= tgt_next;
        outw   <= outw_next;
        cnt    <= cnt_next;
        ptr    <= ptr_next;
        lim    <= lim_next;
        seen   <= seen_next;
        for (int i = 0; i < AXIS_COUNT; i++) pos[i] <= pos_next[i];
        o_valid <= 1'b1;
      end else if (o_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) o_res <= res;
  end

  // Teach memory: one write port, registered read at the replay pointer
  always_ff @(posedge clk) begin
    if (fire && we) mem[cnt[ADDR_W-1:0]] <= wdata;
    rd <= mem[raddr[ADDR_W-1:0]];
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    int'(cnt) <= TEACH_DEPTH)
    else $error("teach count beyond table depth");

  a_ptr_in_table: assert property (@(posedge clk) disable iff (rst)
    mode == M_REPLAY_MOVE |-> ptr < cnt)
    else $error("replay move outside stored entries");

  a_idle_stop: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_res.busy_res |-> o_res.drive_dir == DIR_STOP)
    else $error("motor driven while idle");

endmodule

>>> rtl/four_axis_step_teach_replay.sv
// Top level of the four-axis stepped motor sequencer with teach and replay.
//
// Usage:
//  s_axis carries one item per clock tick of the motion logic: tuser holds the
//  command (tick, select, step left/right, save, replay, recalibrate), tdata
//  holds the axis choice and the sampled end and pulse switch levels.
//  m_axis returns exactly one result item per input item: drive axis and
//  direction, busy, limit and refusal flags, the selected axis and its position,
//  and the number of taught entries.
//  cfg writes the per-axis maximum step position (index 0..3); write only while
//  idle.
// Path: an item passes the front register, a queue slot and the result register
//  before its result is valid, when the output is free.
// Throughput: one item per cycle sustained while m_axis_tready is high; the
//  front and the sequencer are parted by a two-entry queue, and the result
//  register takes a new item in the cycle the previous result is taken.
// Reset: homing of axis one starts at once; the teach table holds no entries.
// Stall: when m_axis_tready is low the result holds, the queue fills, and then
//  s_axis_tready drops; no item is lost or repeated.
module four_axis_step_teach_replay #(
  parameter int TEACH_DEPTH   = 128,
  parameter int AXIS_COUNT    = 4,
  parameter int POSITION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // axis_choice[1:0], end_switches[5:2], pulse_switches[9:6]
  input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // drive_axis[1:0], drive_dir[3:2], busy_res[4],
                                      // at_limit[5], refused[6], selected_position[14:7],
                                      // selected_now[16:15], taught_count[24:17]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import fastr_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  res_t  res;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  fastr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_item   (f_item)
  );

  fastr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .w_valid (f_valid),
    .w_ready (f_ready),
    .w_item  (f_item),
    .r_valid (q_valid),
    .r_ready (q_ready),
    .r_item  (q_item)
  );

  fastr_back #(
    .TEACH_DEPTH   (TEACH_DEPTH),
    .AXIS_COUNT    (AXIS_COUNT),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_idx (cfg_index),
    .cfg_val (cfg_data),
    .o_valid (m_axis_tvalid),
    .o_ready (m_axis_tready),
    .o_res   (res)
  );

  assign m_axis_tdata = res;

endmodule
